[hdl/hashed_slot_cache_lru_top_defines.svh]
// Assertion macros shared by the cache index modules
`ifndef HASHED_SLOT_CACHE_LRU_TOP_DEFINES_SVH
`define HASHED_SLOT_CACHE_LRU_TOP_DEFINES_SVH
// implication checked on every clock edge outside reset
`define HSC_ASSERT_IMP(label, clk, rstn, cond, prop, msg) \
label: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (prop)) \
    else $error(msg);
// implication checked in the cycle after the condition
`define HSC_ASSERT_NEXT(label, clk, rstn, cond, prop, msg) \
label: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (prop)) \
    else $error(msg);
`endif

[hdl/hsc_pkg.sv]
//------------------------------------------------------------------------------
// hsc_pkg
// Shared types and constants of the slot cache index.
//------------------------------------------------------------------------------
`default_nettype none
package hsc_pkg;
    localparam int SLOTS_DEF = 16;
    localparam int BUCKET_FACTOR_DEF = 4;
    localparam int MAX_LEN_DEF = 1024;

    localparam logic [1:0] ACT_INS_AUTO = 2'd0;
    localparam logic [1:0] ACT_INS_SLOT = 2'd1;
    localparam logic [1:0] ACT_LOOKUP   = 2'd2;
    localparam logic [1:0] ACT_RETRIEVE = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_TOO_LONG = 2'd1;
    localparam logic [1:0] ST_NOT_FND  = 2'd2;
    localparam logic [1:0] ST_LEN_MIS  = 2'd3;

    // one request as handed from the front to the back
    typedef struct packed {
        logic [1:0]  action;
        logic [5:0]  bucket;
        logic [3:0]  slot;
        logic [10:0] length;
    } hsc_req_t;
endpackage
`default_nettype wire

[hdl/hsc_front.sv]
//------------------------------------------------------------------------------
// hsc_front
// Accepts requests, reduces bucket and slot, holds a two-entry queue.
//------------------------------------------------------------------------------
`default_nettype none
`include "hashed_slot_cache_lru_top_defines.svh"
module hsc_front
    import hsc_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire hsc_req_t in_req,
    output logic          q_valid,
    input  wire logic     q_pop,
    output hsc_req_t      q_req
);
    localparam int SLOTS = SLOTS_DEF;
    localparam int BUCKET_FACTOR = BUCKET_FACTOR_DEF;
    localparam int NB = SLOTS * BUCKET_FACTOR;

    hsc_req_t   ent_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    hsc_req_t   red;
    logic       push;

    // reduce bucket and slot to the configured counts
    always_comb begin
        red = in_req;
        red.bucket = 6'((32'(in_req.bucket)) % NB);
        red.slot = 4'((32'(in_req.slot)) % SLOTS);
    end

    assign in_ready = (cnt_reg != 2'd2);
    assign push = in_valid && in_ready;
    assign q_valid = (cnt_reg != 2'd0);
    assign q_req = ent_reg[rp_reg];

    // advance queue pointers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (push) wp_reg <= ~wp_reg;
            if (q_pop) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(q_pop);
        end
        if (push) ent_reg[wp_reg] <= red;
    end

    `HSC_ASSERT_IMP(a_no_pop_empty, aclk, aresetn, q_pop, q_valid, "pop of empty queue")
    `HSC_ASSERT_IMP(a_cnt_range, aclk, aresetn, 1'b1, cnt_reg != 2'd3, "queue count overflow")
    `HSC_ASSERT_NEXT(a_full_after, aclk, aresetn, push && !q_pop && cnt_reg == 2'd1,
        cnt_reg == 2'd2, "queue count lost a push")
endmodule
`default_nettype wire

[hdl/hsc_back.sv]
//------------------------------------------------------------------------------
// hsc_back
// Executes requests on the maps and the recency order in a state machine.
//------------------------------------------------------------------------------
`default_nettype none
`include "hashed_slot_cache_lru_top_defines.svh"
module hsc_back
    import hsc_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEF
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     q_valid,
    output logic          q_pop,
    input  wire hsc_req_t q_req,
    output logic          out_valid,
    input  wire logic     out_ready,
    output logic [1:0]    out_status,
    output logic [3:0]    out_slot,
    output logic [10:0]   out_length
);
    localparam int SLOTS = SLOTS_DEF;
    localparam int BUCKET_FACTOR = BUCKET_FACTOR_DEF;
    localparam int NB = SLOTS * BUCKET_FACTOR;
    localparam int SW = $clog2(SLOTS);
    localparam int BW = (NB > 1) ? $clog2(NB) : 1;
    localparam int CW = $clog2(SLOTS + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_READ = 3'd1;
    localparam logic [2:0] S_EXEC = 3'd2;
    localparam logic [2:0] S_EVB  = 3'd3;
    localparam logic [2:0] S_WR   = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    // bucket map in memory with a valid bit per bucket
    logic [SW-1:0] bmap_mem [NB];
    logic [NB-1:0] bm_valid_reg;
    logic [SW-1:0] bm_rd_reg;
    logic [SLOTS-1:0] sb_valid_reg;
    logic [BW-1:0] sb_bucket_reg [SLOTS];
    logic [10:0]   slen_reg [SLOTS];
    logic [SW-1:0] rec_reg [SLOTS];
    logic [CW-1:0] rcnt_reg;

    logic [2:0]    state_reg;
    hsc_req_t      req_reg;
    logic [SW-1:0] s_reg;
    logic [BW-1:0] b_reg;
    logic [1:0]    st_reg;
    logic [3:0]    so_reg;
    logic [10:0]   lo_reg;
    logic          evb_reg;
    logic [SW-1:0] evs_reg;

    logic [SW-1:0] free_s;
    logic          free_f;
    logic [SW-1:0] lru_s;
    logic [SLOTS-1:0] hit_vec;
    logic [CW-1:0] pos;
    logic          found;

    // first free slot search
    always_comb begin
        free_s = '0;
        free_f = 1'b0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!sb_valid_reg[i]) begin
                free_s = SW'(i);
                free_f = 1'b1;
            end
        end
    end

    assign lru_s = (rcnt_reg != '0) ? rec_reg[SW'(rcnt_reg - CW'(1))] : '0;

    // locate the touched slot in the recency order
    always_comb begin
        pos = rcnt_reg;
        found = 1'b0;
        for (int i = 0; i < SLOTS; i++) begin
            hit_vec[i] = (CW'(i) < rcnt_reg) && (rec_reg[i] == s_reg);
        end
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (hit_vec[i]) begin
                pos = CW'(i);
                found = 1'b1;
            end
        end
        if (!found) pos = (rcnt_reg < CW'(SLOTS)) ? rcnt_reg : CW'(SLOTS - 1);
    end

    assign q_pop = (state_reg == S_IDLE) && q_valid;
    assign out_valid = (state_reg == S_OUT);
    assign out_status = st_reg;
    assign out_slot = so_reg;
    assign out_length = lo_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            bm_valid_reg <= '0;
            sb_valid_reg <= '0;
            rcnt_reg <= '0;
            for (int i = 0; i < SLOTS; i++) slen_reg[i] <= '0;
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (q_pop) begin
                        req_reg <= q_req;
                        b_reg <= BW'(q_req.bucket);
                        s_reg <= SW'(q_req.slot);
                        state_reg <= S_READ;
                    end
                end
                S_READ: begin
                    // read bucket map, choose slot for auto insert
                    bm_rd_reg <= bmap_mem[b_reg];
                    if (req_reg.action == ACT_INS_AUTO)
                        s_reg <= free_f ? free_s : lru_s;
                    state_reg <= S_EXEC;
                end
                S_EXEC: begin
                    case (req_reg.action) inside
                        ACT_INS_AUTO, ACT_INS_SLOT: begin
                            if (32'(req_reg.length) > MAX_LEN) begin
                                st_reg <= ST_TOO_LONG;
                                so_reg <= '0;
                                lo_reg <= '0;
                                state_reg <= S_OUT;
                            end else begin
                                st_reg <= ST_OK;
                                so_reg <= 4'(s_reg);
                                lo_reg <= req_reg.length;
                                // evict current content of the slot
                                if (sb_valid_reg[s_reg]) begin
                                    bm_valid_reg[sb_bucket_reg[s_reg]] <= 1'b0;
                                    sb_valid_reg[s_reg] <= 1'b0;
                                end
                                evb_reg <= bm_valid_reg[b_reg] &&
                                    !(sb_valid_reg[s_reg] && sb_bucket_reg[s_reg] == b_reg);
                                evs_reg <= bm_rd_reg;
                                state_reg <= S_EVB;
                            end
                        end
                        ACT_LOOKUP: begin
                            state_reg <= S_OUT;
                            if (!bm_valid_reg[b_reg]) begin
                                st_reg <= ST_NOT_FND;
                                so_reg <= '0;
                                lo_reg <= '0;
                            end else begin
                                so_reg <= 4'(bm_rd_reg);
                                lo_reg <= slen_reg[bm_rd_reg];
                                st_reg <= (slen_reg[bm_rd_reg] == req_reg.length)
                                    ? ST_OK : ST_LEN_MIS;
                            end
                        end
                        default: begin
                            so_reg <= 4'(s_reg);
                            if (!sb_valid_reg[s_reg]) begin
                                st_reg <= ST_NOT_FND;
                                lo_reg <= '0;
                                state_reg <= S_OUT;
                            end else begin
                                st_reg <= ST_OK;
                                lo_reg <= slen_reg[s_reg];
                                state_reg <= S_WR;
                            end
                        end
                    endcase
                end
                S_EVB: begin
                    // evict the holder of the bucket, then install
                    if (evb_reg) begin
                        sb_valid_reg[evs_reg] <= 1'b0;
                        slen_reg[evs_reg] <= '0;
                    end
                    bm_valid_reg[b_reg] <= 1'b1;
                    bmap_mem[b_reg] <= s_reg;
                    state_reg <= S_WR;
                end
                S_WR: begin
                    if (req_reg.action != ACT_RETRIEVE) begin
                        sb_valid_reg[s_reg] <= 1'b1;
                        sb_bucket_reg[s_reg] <= b_reg;
                        slen_reg[s_reg] <= req_reg.length;
                    end
                    // move the slot to the front of the recency order
                    if (!found && rcnt_reg < CW'(SLOTS)) rcnt_reg <= rcnt_reg + CW'(1);
                    for (int i = 1; i < SLOTS; i++) begin
                        if (CW'(i) <= pos) rec_reg[i] <= rec_reg[i-1];
                    end
                    rec_reg[0] <= s_reg;
                    state_reg <= S_OUT;
                end
                S_OUT: begin
                    if (out_ready) state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    `HSC_ASSERT_NEXT(a_out_hold, aclk, aresetn, out_valid && !out_ready,
        out_valid && $stable(out_status), "result dropped while stalled")
    `HSC_ASSERT_IMP(a_cnt_max, aclk, aresetn, 1'b1, rcnt_reg <= CW'(SLOTS),
        "recency count overflow")
    `HSC_ASSERT_IMP(a_pop_idle, aclk, aresetn, q_pop, state_reg == S_IDLE,
        "pop while busy")
endmodule
`default_nettype wire

[hdl/hashed_slot_cache_lru_top.sv]
//------------------------------------------------------------------------------
// hashed_slot_cache_lru_top
// Index of a slot cache: bucket and slot maps, lengths, LRU order.
//------------------------------------------------------------------------------
// Requests enter on s_axis (action, bucket, slot, length); one result per
// request leaves on m_axis (status, slot_out, length_out) in request order.
// A two-entry queue separates the front, which accepts and reduces requests,
// from the back, which reads the maps, evicts and updates the recency order.
// The back steps through read, execute, bucket evict (inserts), write
// (inserts, retrieves that hit) and output; lookups and rejects go from
// execute to output. One request is in the back at a time, and the next
// pops once the result is taken; the queue takes up to two more meanwhile.
// Reset (aresetn low, synchronous) clears all valid bits, stored lengths and
// the recency count; the block accepts requests on the next cycle.
// When m_axis_tready is low the result holds, the back waits, and the
// queue fills before s_axis_tready drops.
//------------------------------------------------------------------------------
`default_nettype none
module hashed_slot_cache_lru_top
    import hsc_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [1:0] action, [7:2] bucket, [11:8] slot, [22:12] length
    input  wire logic [23:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [1:0] status, [5:2] slot_out, [16:6] length_out
    output logic [23:0]      m_axis_tdata
);
    hsc_req_t   in_req, q_req;
    logic       q_valid, q_pop;
    logic [1:0] st;
    logic [3:0] so;
    logic [10:0] lo;

    assign in_req = '{action: s_axis_tdata[1:0], bucket: s_axis_tdata[7:2],
                      slot: s_axis_tdata[11:8], length: s_axis_tdata[22:12]};
    assign m_axis_tdata = {7'd0, lo, so, st};

    hsc_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_req(in_req),
        .q_valid(q_valid), .q_pop(q_pop), .q_req(q_req)
    );

    hsc_back #(.MAX_LEN(MAX_LEN)) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .q_valid(q_valid), .q_pop(q_pop), .q_req(q_req),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .out_status(st), .out_slot(so), .out_length(lo)
    );
endmodule
`default_nettype wire
